### rtl/assert_macros.svh
// assertion macros shared by the mixer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define MMIX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MMIX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/mmix_pkg.sv
// shared types and constants for the mix-minus mixer
package mmix_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int CHANNELS  = 8;
  localparam int SAMPLE_W  = 16;
  // room for the full sum plus one bit for the self-removal difference
  localparam int SUM_W     = SAMPLE_W + $clog2(CHANNELS) + 1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    acc_t;

  localparam acc_t Q15_MAX = acc_t'(32767);
  localparam acc_t Q15_MIN = acc_t'(-32768);

endpackage

### rtl/mmix_gate.sv
// per-connection gate: passes the sample only when mixed and unmuted
module mmix_gate (
  input  mmix_pkg::sample_t sample,
  input  logic              mixed,
  input  logic              muted,
  output mmix_pkg::sample_t contrib
);

  assign contrib = (mixed && !muted) ? sample : '0;

endmodule

### rtl/mmix_sum.sv
// merge stage: adds the gated contributions of all lanes
module mmix_sum (
  input  mmix_pkg::sample_t contrib [mmix_pkg::CHANNELS],
  output mmix_pkg::acc_t    sum
);

  always_comb begin
    sum = '0;
    for (int i = 0; i < mmix_pkg::CHANNELS; i++) begin
      sum = sum + mmix_pkg::acc_t'(contrib[i]);
    end
  end

endmodule

### rtl/mmix_sat.sv
// per-connection output: sum minus own contribution, saturated to q1.15
module mmix_sat (
  input  mmix_pkg::acc_t    sum,
  input  mmix_pkg::sample_t contrib,
  input  logic              remove_self,
  output mmix_pkg::sample_t result
);

  mmix_pkg::acc_t diff;

  assign diff = sum - (remove_self ? mmix_pkg::acc_t'(contrib) : mmix_pkg::acc_t'(0));

  always_comb begin
    if (diff > mmix_pkg::Q15_MAX) begin
      result = mmix_pkg::sample_t'(mmix_pkg::Q15_MAX);
    end else if (diff < mmix_pkg::Q15_MIN) begin
      result = mmix_pkg::sample_t'(mmix_pkg::Q15_MIN);
    end else begin
      result = diff[mmix_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

### rtl/mix_minus_audio_mixer_top.sv
// mix-minus mixer top level: gate lanes, merge adder, saturating output lanes
// an accepted request moves through the gate, sum and saturate registers before out_valid rises
// throughput: one frame per cycle, a new request each cycle while out_ready holds
// a stage holds only while it and every later stage are full and out_ready is low
// reset (sync, rst_n low): pipeline empties and remove_self returns to 1
`include "assert_macros.svh"

module mix_minus_audio_mixer_top (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,

  input  logic              in_valid,
  output logic              in_ready,
  input  mmix_pkg::sample_t in_sample_0,
  input  mmix_pkg::sample_t in_sample_1,
  input  mmix_pkg::sample_t in_sample_2,
  input  mmix_pkg::sample_t in_sample_3,
  input  mmix_pkg::sample_t in_sample_4,
  input  mmix_pkg::sample_t in_sample_5,
  input  mmix_pkg::sample_t in_sample_6,
  input  mmix_pkg::sample_t in_sample_7,
  input  logic [7:0]        in_mix_mask,
  input  logic [7:0]        in_muted_mask,

  output logic              out_valid,
  input  logic              out_ready,
  output mmix_pkg::sample_t out_0,
  output mmix_pkg::sample_t out_1,
  output mmix_pkg::sample_t out_2,
  output mmix_pkg::sample_t out_3,
  output mmix_pkg::sample_t out_4,
  output mmix_pkg::sample_t out_5,
  output mmix_pkg::sample_t out_6,
  output mmix_pkg::sample_t out_7
);

  localparam int CH = mmix_pkg::CHANNELS;

  logic              remove_self_r;

  mmix_pkg::sample_t in_smp     [mmix_pkg::NUM_SLOTS];
  mmix_pkg::sample_t gate_c     [CH];
  mmix_pkg::sample_t s1_c_r     [CH];
  mmix_pkg::sample_t s2_c_r     [CH];
  mmix_pkg::acc_t    sum;
  mmix_pkg::acc_t    s2_sum_r;
  mmix_pkg::sample_t lane_out   [mmix_pkg::NUM_SLOTS];
  mmix_pkg::sample_t out_r      [mmix_pkg::NUM_SLOTS];

  logic s1_v_r, s1_v_nxt;
  logic s2_v_r, s2_v_nxt;
  logic out_v_r, out_v_nxt;
  logic out_adv, s2_ready, s1_ready;
  logic pipe_full;

  assign in_smp[0] = in_sample_0;
  assign in_smp[1] = in_sample_1;
  assign in_smp[2] = in_sample_2;
  assign in_smp[3] = in_sample_3;
  assign in_smp[4] = in_sample_4;
  assign in_smp[5] = in_sample_5;
  assign in_smp[6] = in_sample_6;
  assign in_smp[7] = in_sample_7;

  // stall chain: a stage moves when it is empty or the next one moves
  assign out_adv  = !out_v_r || out_ready;
  assign s2_ready = !s2_v_r || out_adv;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ready = s1_ready;

  assign pipe_full = s1_v_r && s2_v_r && out_v_r;

  always_comb begin
    s1_v_nxt  = s1_ready ? in_valid : s1_v_r;
    s2_v_nxt  = s2_ready ? s1_v_r : s2_v_r;
    out_v_nxt = out_adv ? s2_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r        <= 1'b0;
      s2_v_r        <= 1'b0;
      out_v_r       <= 1'b0;
      remove_self_r <= 1'b1;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_wr_en) begin
        remove_self_r <= cfg_wr_data;
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < CH; g++) begin : g_lane
      mmix_gate u_gate (
        .sample  (in_smp[g]),
        .mixed   (in_mix_mask[g]),
        .muted   (in_muted_mask[g]),
        .contrib (gate_c[g])
      );

      mmix_sat u_sat (
        .sum         (s2_sum_r),
        .contrib     (s2_c_r[g]),
        .remove_self (remove_self_r),
        .result      (lane_out[g])
      );
    end
    for (g = CH; g < mmix_pkg::NUM_SLOTS; g++) begin : g_unused
      assign lane_out[g] = '0;
    end
  endgenerate

  mmix_sum u_sum (
    .contrib (s1_c_r),
    .sum     (sum)
  );

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_c_r <= gate_c;
    end
    if (s2_ready) begin
      s2_c_r   <= s1_c_r;
      s2_sum_r <= sum;
    end
    if (out_adv) begin
      out_r <= lane_out;
    end
  end

  assign out_valid = out_v_r;
  assign out_0 = out_r[0];
  assign out_1 = out_r[1];
  assign out_2 = out_r[2];
  assign out_3 = out_r[3];
  assign out_4 = out_r[4];
  assign out_5 = out_r[5];
  assign out_6 = out_r[6];
  assign out_7 = out_r[7];

  `MMIX_ASSERT(a_s1_moves_on, s1_v_r && s2_ready |=> s2_v_r, "sum stage lost a request")
  `MMIX_ASSERT(a_full_blocks_in, pipe_full && !out_ready |-> !in_ready, "accept while full")
  `MMIX_ASSERT_ALWAYS(a_reset_remove_self, !rst_n |=> remove_self_r, "remove_self not set")

endmodule

### bench/mix_lane_checker.sv
`timescale 1ns / 100ps
// lane checker for the mix-minus mixer: predicts each frame's outputs and compares them
module mix_lane_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  mmix_pkg::sample_t in_sample_0,
  input  mmix_pkg::sample_t in_sample_1,
  input  mmix_pkg::sample_t in_sample_2,
  input  mmix_pkg::sample_t in_sample_3,
  input  mmix_pkg::sample_t in_sample_4,
  input  mmix_pkg::sample_t in_sample_5,
  input  mmix_pkg::sample_t in_sample_6,
  input  mmix_pkg::sample_t in_sample_7,
  input  logic [7:0]        in_mix_mask,
  input  logic [7:0]        in_muted_mask,
  input  logic              out_valid,
  input  logic              out_ready,
  input  mmix_pkg::sample_t out_0,
  input  mmix_pkg::sample_t out_1,
  input  mmix_pkg::sample_t out_2,
  input  mmix_pkg::sample_t out_3,
  input  mmix_pkg::sample_t out_4,
  input  mmix_pkg::sample_t out_5,
  input  mmix_pkg::sample_t out_6,
  input  mmix_pkg::sample_t out_7,
  output int                mismatch_cnt,
  output int                lanes_due
);

  typedef logic [mmix_pkg::NUM_SLOTS-1:0][mmix_pkg::SAMPLE_W-1:0] mix_frame_t;

  mix_frame_t in_frame;
  mix_frame_t out_frame;
  mix_frame_t want;
  mix_frame_t lanes_due_q[$];
  logic       remove_self_now;

  assign in_frame  = {in_sample_7, in_sample_6, in_sample_5, in_sample_4,
                      in_sample_3, in_sample_2, in_sample_1, in_sample_0};
  assign out_frame = {out_7, out_6, out_5, out_4, out_3, out_2, out_1, out_0};

  function automatic mix_frame_t mix_minus_lanes(input mix_frame_t smp, input logic [7:0] mix,
                                                 input logic [7:0] mute, input logic drop_self);
    int                total;
    int                lane;
    mmix_pkg::sample_t own;
    mix_frame_t        lanes;
    total = 0;
    lanes = '0;
    for (int i = 0; i < mmix_pkg::CHANNELS; i++) begin
      own = smp[i];
      if (mix[i] && !mute[i]) total += own;
    end
    for (int i = 0; i < mmix_pkg::CHANNELS; i++) begin
      own  = smp[i];
      lane = total;
      // a muted or unmixed connection hears the plain sum
      if (drop_self && mix[i] && !mute[i]) lane -= own;
      if (lane > mmix_pkg::Q15_MAX) lane = mmix_pkg::Q15_MAX;
      else if (lane < mmix_pkg::Q15_MIN) lane = mmix_pkg::Q15_MIN;
      lanes[i] = lane[mmix_pkg::SAMPLE_W-1:0];
    end
    return lanes;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      remove_self_now = 1'b1;
      lanes_due_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (lanes_due_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: output frame with no request outstanding", $time);
        end else begin
          want = lanes_due_q.pop_front();
          for (int i = 0; i < mmix_pkg::NUM_SLOTS; i++) begin
            if (out_frame[i] !== want[i]) begin
              mismatch_cnt++;
              if (mismatch_cnt <= 10)
                $display("%0t: out_%0d expected %0d, got %0d", $time, i,
                         $signed(want[i]), $signed(out_frame[i]));
            end
          end
        end
      end
      if (in_valid && in_ready)
        lanes_due_q = {lanes_due_q, mix_minus_lanes(in_frame, in_mix_mask, in_muted_mask,
                                                    remove_self_now)};
      if (cfg_wr_en) remove_self_now = cfg_wr_data;
    end
    lanes_due = lanes_due_q.size();
  end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// testbench top for the mix-minus mixer: frame stimulus, output stalls and verdict
module tb;

  typedef logic [mmix_pkg::NUM_SLOTS-1:0][mmix_pkg::SAMPLE_W-1:0] mix_frame_t;

  localparam int QUIET_LIMIT = 2000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic              cfg_wr_data;
  logic              in_valid;
  logic              in_ready;
  mmix_pkg::sample_t in_sample_0, in_sample_1, in_sample_2, in_sample_3;
  mmix_pkg::sample_t in_sample_4, in_sample_5, in_sample_6, in_sample_7;
  logic [7:0]        in_mix_mask;
  logic [7:0]        in_muted_mask;
  logic              out_valid;
  logic              out_ready;
  mmix_pkg::sample_t out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7;
  int                mismatch_cnt;
  int                lanes_due;

  mix_frame_t drive_frame;
  int         idle_odds;
  int         quiet_cycles;

  assign {in_sample_7, in_sample_6, in_sample_5, in_sample_4,
          in_sample_3, in_sample_2, in_sample_1, in_sample_0} = drive_frame;

  mix_minus_audio_mixer_top uut (.*);

  mix_lane_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic mix_frame_t all_lanes(input logic [15:0] v);
    mix_frame_t f;
    for (int i = 0; i < mmix_pkg::NUM_SLOTS; i++) f[i] = v;
    return f;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic mix_frame_t rand_frame();
    mix_frame_t f;
    for (int i = 0; i < mmix_pkg::NUM_SLOTS; i++) f[i] = rand_sample();
    return f;
  endfunction

  function automatic logic [7:0] rand_mask();
    case ($urandom_range(0, 3))
      0:       return 8'hff;
      1:       return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_frame(input mix_frame_t smp, input logic [7:0] mix,
                            input logic [7:0] mute);
    @(negedge clk);
    if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    drive_frame   <= smp;
    in_mix_mask   <= mix;
    in_muted_mask <= mute;
    do @(posedge clk); while (!in_ready);
  endtask

  // only touch the register once the pipeline has drained
  task automatic write_remove_self(input logic value);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (lanes_due == 0);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_directed();
    mix_frame_t f;
    send_frame(all_lanes(16'h0000), 8'hff, 8'h00);
    send_frame(all_lanes(16'h7fff), 8'hff, 8'h00);
    send_frame(all_lanes(16'h8000), 8'hff, 8'h00);
    // empty mix, then everything muted
    send_frame(rand_frame(), 8'h00, 8'h00);
    send_frame(rand_frame(), 8'hff, 8'hff);
    f    = rand_frame();
    f[0] = 16'd1234;
    send_frame(f, 8'h01, 8'h00);
    // own-sample removal lands exactly on both rails
    f    = all_lanes(16'h0000);
    f[0] = 16'h8000;
    f[1] = 16'h7fff;
    send_frame(f, 8'h03, 8'h00);
    f    = rand_frame();
    f[0] = 16'h7fff;
    f[1] = 16'h0001;
    send_frame(f, 8'h03, 8'h00);
    for (int i = 0; i < mmix_pkg::NUM_SLOTS; i++) f[i] = i[0] ? 16'h8000 : 16'h7fff;
    send_frame(f, 8'hff, 8'h00);
    send_frame(rand_frame(), 8'h0f, 8'h05);
    send_frame(rand_frame(), 8'haa, 8'h55);
    send_frame(rand_frame(), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 1'b0;
    in_valid      = 1'b0;
    drive_frame   = '0;
    in_mix_mask   = 8'h00;
    in_muted_mask = 8'h00;
    idle_odds     = 4;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    write_remove_self(1'b0);
    run_directed();

    // busy, lighter and calm stretches; the closing one never idles
    for (int ph = 0; ph < 5; ph++) begin
      write_remove_self(ph % 2 == 0);
      idle_odds = (ph == 2 || ph == 4) ? 0 : 3 + 2 * ph;
      repeat (100) send_frame(rand_frame(), rand_mask(), rand_mask() & rand_mask());
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (lanes_due == 0);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && lanes_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
